// ----- rtl/tantb_pkg.sv -----
`default_nettype none

package tantb_pkg;

  localparam int POS_W     = 24;
  localparam int UV_W      = 16;
  localparam int NRM_W     = 16;
  localparam int SUM_W     = 18;
  localparam int VEC_W     = 16;
  localparam int IN_W      = 3 * POS_W + 2 * UV_W + 3 * NRM_W;
  localparam int OUT_W     = 6 * VEC_W;
  localparam int OUT_USR_W = 3;
  localparam int MUL_W     = 33;
  localparam int ACC_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int DNUM_W    = 48;
  localparam int DDEN_W    = 32;
  localparam int BQ_W      = 21;

  // 3 * 2^14: the integer normal sum is three times the mean normal in Q1.14.
  localparam logic [DDEN_W-1:0] NORM_K      = 32'd49152;
  localparam logic [DNUM_W-1:0] NORM_K_HALF = 48'd24576;

  // ceil(2^23 / 3): floor(y / 3) equals (y * RECIP3) >> 23 for every y below 2^23.
  localparam logic [MUL_W-1:0] RECIP3    = 33'd2796203;
  localparam int               RECIP3_SH = 23;

  // Block scaling windows for the raw tangent and the projected tangent.
  localparam logic [ACC_W-1:0] BS_T_HI = 64'h0000_0000_0080_0000;
  localparam logic [ACC_W-1:0] BS_T_LO = 64'h0000_0000_0040_0000;
  localparam logic [ACC_W-1:0] BS_P_HI = 64'h0000_0000_4000_0000;
  localparam logic [ACC_W-1:0] BS_P_LO = 64'h0000_0000_2000_0000;

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? (~v + 64'd1) : v;
    return m;
  endfunction

  // Applies a sign to a quotient magnitude and saturates to 16 bits.
  function automatic logic signed [VEC_W-1:0] sat16(input logic neg,
                                                    input logic [DNUM_W-1:0] q);
    logic signed [VEC_W-1:0] r;
    if (!neg) begin
      r = (q > 48'd32767) ? 16'sh7FFF : q[VEC_W-1:0];
    end else begin
      r = (q > 48'd32768) ? 16'sh8000 : (~q[VEC_W-1:0] + 16'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tantb_mul.sv -----
`default_nettype none

module tantb_mul
  import tantb_pkg::*;
(
  input  wire                           clk,
  input  wire  logic signed [MUL_W-1:0] a,
  input  wire  logic signed [MUL_W-1:0] b,
  output logic signed [ACC_W-1:0]       p
);

  logic signed [2*MUL_W-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[ACC_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/tantb_isqrt.sv -----
`default_nettype none

module tantb_isqrt
  import tantb_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire  logic [ACC_W-1:0]  x,
  output logic                    done,
  output logic [ROOT_W-1:0]       root
);

  logic [ACC_W-1:0] rx;
  logic [ACC_W-1:0] r;
  logic [ACC_W-1:0] bv;
  logic [ACC_W-1:0] trial;
  logic [4:0]       cnt;
  logic             busy;

  assign trial = r + bv;
  assign root  = r[ROOT_W-1:0];

  // One result bit per cycle, for a 64-bit radicand and a 32-bit root.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rx   <= x;
        r    <= '0;
        bv   <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rx >= trial) begin
          rx <= rx - trial;
          r  <= (r >> 1) + bv;
        end else begin
          r <= r >> 1;
        end
        bv  <= bv >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tantb_div.sv -----
`default_nettype none

module tantb_div
  import tantb_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire  logic [DNUM_W-1:0]  num,
  input  wire  logic [DDEN_W-1:0]  den,
  output logic                     done,
  output logic [DNUM_W-1:0]        quo
);

  logic [DDEN_W-1:0] rem;
  logic [DDEN_W-1:0] dd;
  logic [DDEN_W:0]   shifted;
  logic [DDEN_W:0]   diff;
  logic              ge;
  logic [5:0]        cnt;
  logic              busy;

  assign shifted = {rem, quo[DNUM_W-1]};
  assign diff    = shifted - {1'b0, dd};
  assign ge      = shifted >= {1'b0, dd};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= num;
        dd   <= den;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DDEN_W-1:0] : shifted[DDEN_W-1:0];
        quo <= {quo[DNUM_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/triangle_tangent_basis.sv -----
`default_nettype none

// Channel   Dir  tdata                                   tuser                  tlast
// s_axis    in   pos x/y/z, tex u/v, norm x/y/z (152b)   mesh_start             -
// m_axis    out  tangent x/y/z, bitan x/y/z (96b)        degenerate, slot (3b)  last_of_triangle
//
// The first two vertices of a triangle are stored on acceptance. The third one starts
// a sequence on one shared 33x33 multiplier, a bit-serial square root and a
// bit-serial divider, made up mostly of three divisions, the square root and two
// one-bit-per-cycle block scaling passes.
// A zero determinant ends the sequence with a degenerate result.
// The three result words then leave one per accepted cycle; no vertex is taken
// until the last of them is gone. Reset is synchronous and drops held vertices.

module triangle_tangent_basis
  import tantb_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
  input  wire  [IN_W-1:0]      s_axis_tdata,
  // mesh_start
  input  wire  [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // tangent_x, tangent_y, tangent_z, bitan_x, bitan_y, bitan_z
  output logic [OUT_W-1:0]     m_axis_tdata,
  // degenerate, vertex_slot[1:0]
  output logic [OUT_USR_W-1:0] m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_BS     = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;
  localparam logic [2:0] ST_RECIP  = 3'd7;

  localparam logic [4:0] OP_DET_A = 5'd0;
  localparam logic [4:0] OP_DET_B = 5'd1;
  localparam logic [4:0] OP_TX_A  = 5'd2;
  localparam logic [4:0] OP_TX_B  = 5'd3;
  localparam logic [4:0] OP_TY_A  = 5'd4;
  localparam logic [4:0] OP_TY_B  = 5'd5;
  localparam logic [4:0] OP_TZ_A  = 5'd6;
  localparam logic [4:0] OP_TZ_B  = 5'd7;
  localparam logic [4:0] OP_DOT_X = 5'd8;
  localparam logic [4:0] OP_DOT_Y = 5'd9;
  localparam logic [4:0] OP_DOT_Z = 5'd10;
  localparam logic [4:0] OP_PX_A  = 5'd11;
  localparam logic [4:0] OP_PX_B  = 5'd12;
  localparam logic [4:0] OP_PX_C  = 5'd13;
  localparam logic [4:0] OP_PY_A  = 5'd14;
  localparam logic [4:0] OP_PY_B  = 5'd15;
  localparam logic [4:0] OP_PY_C  = 5'd16;
  localparam logic [4:0] OP_PZ_A  = 5'd17;
  localparam logic [4:0] OP_PZ_B  = 5'd18;
  localparam logic [4:0] OP_PZ_C  = 5'd19;
  localparam logic [4:0] OP_SS_X  = 5'd20;
  localparam logic [4:0] OP_SS_Y  = 5'd21;
  localparam logic [4:0] OP_SS_Z  = 5'd22;
  localparam logic [4:0] OP_BX_A  = 5'd23;
  localparam logic [4:0] OP_BX_B  = 5'd24;
  localparam logic [4:0] OP_BY_A  = 5'd25;
  localparam logic [4:0] OP_BY_B  = 5'd26;
  localparam logic [4:0] OP_BZ_A  = 5'd27;
  localparam logic [4:0] OP_BZ_B  = 5'd28;

  localparam logic [1:0] ACC_LOAD = 2'd0;
  localparam logic [1:0] ACC_ADD  = 2'd1;
  localparam logic [1:0] ACC_SUB  = 2'd2;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_22 = 2'd1;
  localparam logic [1:0] SH_28 = 2'd2;

  logic [2:0] state;
  logic [1:0] vcount;
  logic [1:0] cnt_eff;
  logic       ph;
  logic [4:0] op;
  logic [1:0] dcnt;
  logic [1:0] slot;
  logic       bs_sel;
  logic       det_neg;
  logic       deg;

  logic signed [POS_W-1:0] in_pos [3];
  logic signed [UV_W-1:0]  in_uv  [2];
  logic signed [NRM_W-1:0] in_n   [3];

  logic signed [POS_W-1:0] p0 [3];
  logic signed [POS_W-1:0] p1 [3];
  logic signed [POS_W-1:0] p2 [3];
  logic signed [UV_W-1:0]  uv0 [2];
  logic signed [UV_W-1:0]  uv1 [2];
  logic signed [UV_W-1:0]  uv2 [2];
  logic signed [SUM_W-1:0] nsum [3];

  logic signed [UV_W:0]  du1, dv1, du2, dv2;
  logic signed [POS_W:0] dp1 [3];
  logic signed [POS_W:0] dp2 [3];

  // Sign and magnitude of the vector being scaled: raw tangent, then projection.
  logic [ACC_W-1:0]        mg [3];
  logic                    ng [3];
  logic signed [POS_W-1:0] ts [3];
  logic [ACC_W-1:0]        m01, mx, bs_hi, bs_lo;

  logic signed [ACC_W-1:0] acc, dot, prod, prod_sh, acc_new, tvv;
  logic signed [MUL_W-1:0] ma, mb;
  logic [1:0]              acc_mode, acc_sh;

  // Bitangent numerator, rounded and scaled down by 2^14, waiting for the divide by 3.
  logic [ACC_W-1:0]        bmag;
  logic [BQ_W-1:0]         bq;
  logic                    bneg;

  logic [ROOT_W-1:0]       mroot;
  logic                    sq_start, sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    dv_start, dv_done;
  logic [DNUM_W-1:0]       dv_num, dv_quo;
  logic [DDEN_W-1:0]       dv_den;

  logic signed [VEC_W-1:0] tan [3];
  logic signed [VEC_W-1:0] bt  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = s_axis_tdata[POS_W*i +: POS_W];
      in_n[i]   = s_axis_tdata[3*POS_W + 2*UV_W + NRM_W*i +: NRM_W];
      dp1[i]    = (POS_W+1)'(p1[i]) - (POS_W+1)'(p0[i]);
      dp2[i]    = (POS_W+1)'(p2[i]) - (POS_W+1)'(p0[i]);
      ts[i]     = ng[i] ? (~mg[i][POS_W-1:0] + 24'd1) : mg[i][POS_W-1:0];
    end
    for (int j = 0; j < 2; j++) begin
      in_uv[j] = s_axis_tdata[3*POS_W + UV_W*j +: UV_W];
    end
  end

  assign du1 = (UV_W+1)'(uv1[0]) - (UV_W+1)'(uv0[0]);
  assign dv1 = (UV_W+1)'(uv1[1]) - (UV_W+1)'(uv0[1]);
  assign du2 = (UV_W+1)'(uv2[0]) - (UV_W+1)'(uv0[0]);
  assign dv2 = (UV_W+1)'(uv2[1]) - (UV_W+1)'(uv0[1]);

  assign m01   = (mg[0] > mg[1]) ? mg[0] : mg[1];
  assign mx    = (m01 > mg[2]) ? m01 : mg[2];
  assign bs_hi = bs_sel ? BS_P_HI : BS_T_HI;
  assign bs_lo = bs_sel ? BS_P_LO : BS_T_LO;

  // Microprogram: operands and accumulate action for each multiply step.
  // The dot product is split at bit 22 so each partial product stays narrow.
  always_comb begin
    ma       = '0;
    mb       = '0;
    acc_mode = ACC_LOAD;
    acc_sh   = SH_0;
    unique case (op)
      OP_DET_A: begin ma = MUL_W'(du1); mb = MUL_W'(dv2); end
      OP_DET_B: begin ma = MUL_W'(dv1); mb = MUL_W'(du2); acc_mode = ACC_SUB; end
      OP_TX_A:  begin ma = MUL_W'(dp1[0]); mb = MUL_W'(dv2); end
      OP_TX_B:  begin ma = MUL_W'(dp2[0]); mb = MUL_W'(dv1); acc_mode = ACC_SUB; end
      OP_TY_A:  begin ma = MUL_W'(dp1[1]); mb = MUL_W'(dv2); end
      OP_TY_B:  begin ma = MUL_W'(dp2[1]); mb = MUL_W'(dv1); acc_mode = ACC_SUB; end
      OP_TZ_A:  begin ma = MUL_W'(dp1[2]); mb = MUL_W'(dv2); end
      OP_TZ_B:  begin ma = MUL_W'(dp2[2]); mb = MUL_W'(dv1); acc_mode = ACC_SUB; end
      OP_DOT_X: begin ma = MUL_W'(nsum[0]); mb = MUL_W'(ts[0]); end
      OP_DOT_Y: begin ma = MUL_W'(nsum[1]); mb = MUL_W'(ts[1]); acc_mode = ACC_ADD; end
      OP_DOT_Z: begin ma = MUL_W'(nsum[2]); mb = MUL_W'(ts[2]); acc_mode = ACC_ADD; end
      OP_PX_A:  begin ma = MUL_W'(ts[0]); mb = 33'sd9; acc_sh = SH_28; end
      OP_PX_B:  begin
        ma = MUL_W'(nsum[0]); mb = MUL_W'(dot >>> 22); acc_mode = ACC_SUB; acc_sh = SH_22;
      end
      OP_PX_C:  begin ma = MUL_W'(nsum[0]); mb = {11'b0, dot[21:0]}; acc_mode = ACC_SUB; end
      OP_PY_A:  begin ma = MUL_W'(ts[1]); mb = 33'sd9; acc_sh = SH_28; end
      OP_PY_B:  begin
        ma = MUL_W'(nsum[1]); mb = MUL_W'(dot >>> 22); acc_mode = ACC_SUB; acc_sh = SH_22;
      end
      OP_PY_C:  begin ma = MUL_W'(nsum[1]); mb = {11'b0, dot[21:0]}; acc_mode = ACC_SUB; end
      OP_PZ_A:  begin ma = MUL_W'(ts[2]); mb = 33'sd9; acc_sh = SH_28; end
      OP_PZ_B:  begin
        ma = MUL_W'(nsum[2]); mb = MUL_W'(dot >>> 22); acc_mode = ACC_SUB; acc_sh = SH_22;
      end
      OP_PZ_C:  begin ma = MUL_W'(nsum[2]); mb = {11'b0, dot[21:0]}; acc_mode = ACC_SUB; end
      OP_SS_X:  begin ma = {3'b0, mg[0][29:0]}; mb = {3'b0, mg[0][29:0]}; end
      OP_SS_Y:  begin
        ma = {3'b0, mg[1][29:0]}; mb = {3'b0, mg[1][29:0]}; acc_mode = ACC_ADD;
      end
      OP_SS_Z:  begin
        ma = {3'b0, mg[2][29:0]}; mb = {3'b0, mg[2][29:0]}; acc_mode = ACC_ADD;
      end
      OP_BX_A:  begin ma = MUL_W'(nsum[1]); mb = MUL_W'(tan[2]); end
      OP_BX_B:  begin ma = MUL_W'(nsum[2]); mb = MUL_W'(tan[1]); acc_mode = ACC_SUB; end
      OP_BY_A:  begin ma = MUL_W'(nsum[2]); mb = MUL_W'(tan[0]); end
      OP_BY_B:  begin ma = MUL_W'(nsum[0]); mb = MUL_W'(tan[2]); acc_mode = ACC_SUB; end
      OP_BZ_A:  begin ma = MUL_W'(nsum[0]); mb = MUL_W'(tan[1]); end
      OP_BZ_B:  begin ma = MUL_W'(nsum[1]); mb = MUL_W'(tan[0]); acc_mode = ACC_SUB; end
      default:  begin ma = '0; mb = '0; end
    endcase
    // The bitangent's division by 3 * 2^14 is a shift followed by a multiply by 1/3.
    if (state == ST_RECIP) begin
      ma = MUL_W'(bq);
      mb = RECIP3;
    end
  end

  always_comb begin
    case (acc_sh)
      SH_22:   prod_sh = prod <<< 22;
      SH_28:   prod_sh = prod <<< 28;
      default: prod_sh = prod;
    endcase
    case (acc_mode)
      ACC_ADD: acc_new = acc + prod_sh;
      ACC_SUB: acc_new = acc - prod_sh;
      default: acc_new = prod_sh;
    endcase
    tvv = det_neg ? -acc_new : acc_new;
  end

  assign bmag   = mag64(acc_new);
  assign dv_num = (DNUM_W'(mg[dcnt][29:0]) << 14) + DNUM_W'(mroot >> 1);
  assign dv_den = mroot;

  tantb_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  tantb_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (acc),
    .done  (sq_done),
    .root  (sq_root)
  );

  tantb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign cnt_eff = s_axis_tuser[0] ? 2'd0 : vcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vcount   <= '0;
      ph       <= 1'b0;
      op       <= OP_DET_A;
      dcnt     <= '0;
      slot     <= '0;
      sq_start <= 1'b0;
      dv_start <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            case (cnt_eff)
              2'd1: begin
                p1     <= in_pos;
                uv1    <= in_uv;
                for (int i = 0; i < 3; i++) nsum[i] <= nsum[i] + SUM_W'(in_n[i]);
                vcount <= 2'd2;
              end
              2'd2: begin
                p2     <= in_pos;
                uv2    <= in_uv;
                for (int i = 0; i < 3; i++) nsum[i] <= nsum[i] + SUM_W'(in_n[i]);
                vcount <= 2'd0;
                deg    <= 1'b0;
                op     <= OP_DET_A;
                ph     <= 1'b0;
                state  <= ST_MUL;
              end
              default: begin
                p0     <= in_pos;
                uv0    <= in_uv;
                for (int i = 0; i < 3; i++) nsum[i] <= SUM_W'(in_n[i]);
                vcount <= 2'd1;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph  <= 1'b0;
            acc <= acc_new;
            op  <= op + 5'd1;
            case (op) inside
              OP_DET_B: begin
                det_neg <= acc_new[ACC_W-1];
                if (acc_new == '0) begin
                  deg   <= 1'b1;
                  tan   <= '{default: '0};
                  bt    <= '{default: '0};
                  slot  <= '0;
                  state <= ST_OUT;
                end
              end
              OP_TX_B: begin ng[0] <= tvv[ACC_W-1]; mg[0] <= mag64(tvv); end
              OP_TY_B: begin ng[1] <= tvv[ACC_W-1]; mg[1] <= mag64(tvv); end
              OP_TZ_B: begin
                ng[2]  <= tvv[ACC_W-1];
                mg[2]  <= mag64(tvv);
                bs_sel <= 1'b0;
                state  <= ST_BS;
              end
              OP_DOT_Z: dot <= acc_new;
              OP_PX_C: begin ng[0] <= acc_new[ACC_W-1]; mg[0] <= mag64(acc_new); end
              OP_PY_C: begin ng[1] <= acc_new[ACC_W-1]; mg[1] <= mag64(acc_new); end
              OP_PZ_C: begin
                ng[2]  <= acc_new[ACC_W-1];
                mg[2]  <= mag64(acc_new);
                bs_sel <= 1'b1;
                state  <= ST_BS;
              end
              OP_SS_Z: begin
                sq_start <= 1'b1;
                state    <= ST_SQRT;
              end
              OP_BX_B, OP_BY_B, OP_BZ_B: begin
                bneg  <= acc_new[ACC_W-1];
                bq    <= BQ_W'((bmag[DNUM_W-1:0] + NORM_K_HALF) >> 14);
                state <= ST_RECIP;
              end
              default: ;
            endcase
          end
        end
        ST_BS: begin
          // One bit of shift per cycle, all three magnitudes together.
          if (mx == '0) begin
            deg   <= 1'b1;
            tan   <= '{default: '0};
            bt    <= '{default: '0};
            slot  <= '0;
            state <= ST_OUT;
          end else if (mx >= bs_hi) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 1;
          end else if (mx < bs_lo) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 1;
          end else begin
            op    <= bs_sel ? OP_SS_X : OP_DOT_X;
            ph    <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            mroot <= sq_root;
            if (sq_root == '0) begin
              deg   <= 1'b1;
              tan   <= '{default: '0};
              bt    <= '{default: '0};
              slot  <= '0;
              state <= ST_OUT;
            end else begin
              dcnt  <= '0;
              state <= ST_DSTART;
            end
          end
        end
        ST_DSTART: begin
          dv_start <= 1'b1;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (dv_done) begin
            tan[dcnt] <= sat16(ng[dcnt], dv_quo);
            if (dcnt == 2'd2) begin
              dcnt  <= '0;
              op    <= OP_BX_A;
              ph    <= 1'b0;
              state <= ST_MUL;
            end else begin
              dcnt  <= dcnt + 2'd1;
              state <= ST_DSTART;
            end
          end
        end
        ST_RECIP: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph       <= 1'b0;
            bt[dcnt] <= sat16(bneg, DNUM_W'(prod >>> RECIP3_SH));
            if (dcnt == 2'd2) begin
              slot  <= '0;
              state <= ST_OUT;
            end else begin
              dcnt  <= dcnt + 2'd1;
              state <= ST_MUL;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (slot == 2'd2) begin
              slot  <= '0;
              state <= ST_IDLE;
            end else begin
              slot <= slot + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {bt[2], bt[1], bt[0], tan[2], tan[1], tan[0]};
  assign m_axis_tuser  = {slot, deg};
  assign m_axis_tlast  = (slot == 2'd2);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result word is pending");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("degenerate word carries nonzero vectors");

  a_slot_steps: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tuser[2:1] == $past(m_axis_tuser[2:1]) + 2'd1)))
    else $error("vertex slot did not advance");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && vcount == 2'd2) |=>
      !s_axis_tready)
    else $error("third vertex did not start the basis sequence");

endmodule

`default_nettype wire
